>>> hdl/rbst_pkg.sv
// Shared types and constants for the ray/box slab test core.
`timescale 1ns / 1ps

package rbst_pkg;

    // Number of spatial axes handled by the chain (one cell per axis)
    localparam int AXES = 3;

    // Configuration register indexes and index width
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    // Result beat width (hit plus zero fill to a byte)
    localparam int OUT_W = 8;

    // Control flags that ride along with each ray through the chain
    typedef struct packed {
        logic valid;      // stage holds a ray
        logic have;       // at least one non-zero axis folded so far
        logic contained;  // every zero-direction axis passed so far
    } fold_t;

endpackage

>>> hdl/rbst_cell.sv
// One slab-test cell: subtract, multiply and fold for a single axis.
`timescale 1ns / 1ps

module rbst_cell #(
    parameter int CW   = 32,
    parameter int AXIS = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic signed [CW-1:0]  box_lo,
    input  logic signed [CW-1:0]  box_hi,
    input  rbst_pkg::fold_t       flags_in,
    input  logic signed [CW-1:0]  orig_in [rbst_pkg::AXES],
    input  logic signed [CW-1:0]  inv_in  [rbst_pkg::AXES],
    input  logic [rbst_pkg::AXES-1:0] zmask_in,
    input  logic signed [2*CW:0]  near_in,
    input  logic signed [2*CW:0]  far_in,
    output rbst_pkg::fold_t       flags_out,
    output logic signed [CW-1:0]  orig_out [rbst_pkg::AXES],
    output logic signed [CW-1:0]  inv_out  [rbst_pkg::AXES],
    output logic [rbst_pkg::AXES-1:0] zmask_out,
    output logic signed [2*CW:0]  near_out,
    output logic signed [2*CW:0]  far_out
);

    // Stage 1: slab offsets and zero-axis containment
    rbst_pkg::fold_t         f1_reg;
    logic signed [CW-1:0]    orig1_reg [rbst_pkg::AXES];
    logic signed [CW-1:0]    inv1_reg  [rbst_pkg::AXES];
    logic [rbst_pkg::AXES-1:0] zm1_reg;
    logic signed [2*CW:0]    near1_reg;
    logic signed [2*CW:0]    far1_reg;
    logic signed [CW:0]      dlo1_reg;
    logic signed [CW:0]      dhi1_reg;
    logic                    in_ax1_reg;

    // Stage 2: entry and exit times
    rbst_pkg::fold_t         f2_reg;
    logic signed [CW-1:0]    orig2_reg [rbst_pkg::AXES];
    logic signed [CW-1:0]    inv2_reg  [rbst_pkg::AXES];
    logic [rbst_pkg::AXES-1:0] zm2_reg;
    logic signed [2*CW:0]    near2_reg;
    logic signed [2*CW:0]    far2_reg;
    logic signed [2*CW:0]    tlo2_reg;
    logic signed [2*CW:0]    thi2_reg;
    logic                    in_ax2_reg;

    // Stage 3: folded interval
    rbst_pkg::fold_t         f3_reg;
    rbst_pkg::fold_t         f3_next;
    logic signed [CW-1:0]    orig3_reg [rbst_pkg::AXES];
    logic signed [CW-1:0]    inv3_reg  [rbst_pkg::AXES];
    logic [rbst_pkg::AXES-1:0] zm3_reg;
    logic signed [2*CW:0]    near3_reg;
    logic signed [2*CW:0]    far3_reg;
    logic signed [2*CW:0]    near3_next;
    logic signed [2*CW:0]    far3_next;

    logic signed [CW:0]      o_ext;
    logic signed [CW:0]      lo_ext;
    logic signed [CW:0]      hi_ext;
    logic signed [2*CW:0]    t_min;
    logic signed [2*CW:0]    t_max;

    assign o_ext  = {orig_in[AXIS][CW-1], orig_in[AXIS]};
    assign lo_ext = {box_lo[CW-1], box_lo};
    assign hi_ext = {box_hi[CW-1], box_hi};

    // Order the pair, then fold into the running interval
    always_comb
    begin
        if (thi2_reg < tlo2_reg)
        begin
            t_min = thi2_reg;
            t_max = tlo2_reg;
        end
        else
        begin
            t_min = tlo2_reg;
            t_max = thi2_reg;
        end

        f3_next    = f2_reg;
        near3_next = near2_reg;
        far3_next  = far2_reg;
        if (zm2_reg[AXIS])
        begin
            f3_next.contained = f2_reg.contained & in_ax2_reg;
        end
        else
        begin
            f3_next.have = 1'b1;
            if (!f2_reg.have)
            begin
                near3_next = t_min;
                far3_next  = t_max;
            end
            else
            begin
                if (near2_reg < t_min)
                begin
                    near3_next = t_min;
                end
                if (t_max < far2_reg)
                begin
                    far3_next = t_max;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= '0;
            f2_reg <= '0;
            f3_reg <= '0;
        end
        else if (en)
        begin
            f1_reg <= flags_in;
            f2_reg <= f1_reg;
            f3_reg <= f3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            orig1_reg  <= orig_in;
            inv1_reg   <= inv_in;
            zm1_reg    <= zmask_in;
            near1_reg  <= near_in;
            far1_reg   <= far_in;
            dlo1_reg   <= lo_ext - o_ext;
            dhi1_reg   <= hi_ext - o_ext;
            in_ax1_reg <= (o_ext >= lo_ext) && (o_ext <= hi_ext);

            orig2_reg  <= orig1_reg;
            inv2_reg   <= inv1_reg;
            zm2_reg    <= zm1_reg;
            near2_reg  <= near1_reg;
            far2_reg   <= far1_reg;
            tlo2_reg   <= (2*CW+1)'(dlo1_reg) * (2*CW+1)'(inv1_reg[AXIS]);
            thi2_reg   <= (2*CW+1)'(dhi1_reg) * (2*CW+1)'(inv1_reg[AXIS]);
            in_ax2_reg <= in_ax1_reg;

            orig3_reg  <= orig2_reg;
            inv3_reg   <= inv2_reg;
            zm3_reg    <= zm2_reg;
            near3_reg  <= near3_next;
            far3_reg   <= far3_next;
        end
    end

    assign flags_out = f3_reg;
    assign orig_out  = orig3_reg;
    assign inv_out   = inv3_reg;
    assign zmask_out = zm3_reg;
    assign near_out  = near3_reg;
    assign far_out   = far3_reg;

endmodule

>>> hdl/ray_box_slab_test_core.sv
// Top level of the ray versus axis-aligned box slab test core.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         ray: origin xyz, reciprocal direction xyz, zero-direction mask
// m_axis    out        result: hit flag
// cfg       in         box bound write: index, data (no handshake, no read-back)
//
// One ray enters per cycle while the output is not stalled; a result leaves
// through three cells of three stages each, one per axis, and then the output register.
// Throughput is one beat per cycle, set by the per-axis cell chain.
// rst_n clears all valid flags and resets the box bounds to zero.
// A stalled output beat freezes the whole chain, so s_tready drops only
// while a finished result waits and the sink is not ready.

module ray_box_slab_test_core #(
    parameter int CW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Ray beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata, from bit 0: orig_x, orig_y, orig_z, inv_dir_x, inv_dir_y,
    // inv_dir_z, dir_zero_mask (3 bits), zero fill to whole bytes
    input  logic [((6*CW+3+7)/8)*8-1:0] s_tdata,
    // Result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata, from bit 0: hit, zero fill
    output logic [rbst_pkg::OUT_W-1:0] m_tdata,
    // Configuration writes
    input  logic                 cfg_we,
    input  logic [rbst_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [CW-1:0]        cfg_data
);

    localparam int NA = rbst_pkg::AXES;

    // Box bounds
    logic signed [CW-1:0] box_min_reg [NA];
    logic signed [CW-1:0] box_max_reg [NA];

    // Links between cells: entry 0 feeds the first cell
    rbst_pkg::fold_t      flg   [NA+1];
    logic signed [CW-1:0] orig_l [NA+1][NA];
    logic signed [CW-1:0] inv_l  [NA+1][NA];
    logic [NA-1:0]        zm_l  [NA+1];
    logic signed [2*CW:0] near_l [NA+1];
    logic signed [2*CW:0] far_l  [NA+1];

    logic en;
    logic out_valid_reg;
    logic hit_reg;
    logic hit_next;

    // Advance the chain unless a result is held back by the sink
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Config writes; indexes past the box bounds are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbst_pkg::REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                rbst_pkg::REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                rbst_pkg::REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                rbst_pkg::REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                rbst_pkg::REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                rbst_pkg::REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the ray beat into the head of the chain
    always_comb
    begin
        flg[0].valid     = s_tvalid;
        flg[0].have      = 1'b0;
        flg[0].contained = 1'b1;
        for (int i = 0; i < NA; i++)
        begin
            orig_l[0][i] = s_tdata[i*CW +: CW];
            inv_l[0][i]  = s_tdata[(NA+i)*CW +: CW];
        end
        zm_l[0]   = s_tdata[2*NA*CW +: NA];
        near_l[0] = '0;
        far_l[0]  = '0;
    end

    // One cell per axis, each handing the ray and interval to the next
    for (genvar a = 0; a < NA; a++)
    begin : g_cell
        rbst_cell #(
            .CW   (CW),
            .AXIS (a)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .box_lo    (box_min_reg[a]),
            .box_hi    (box_max_reg[a]),
            .flags_in  (flg[a]),
            .orig_in   (orig_l[a]),
            .inv_in    (inv_l[a]),
            .zmask_in  (zm_l[a]),
            .near_in   (near_l[a]),
            .far_in    (far_l[a]),
            .flags_out (flg[a+1]),
            .orig_out  (orig_l[a+1]),
            .inv_out   (inv_l[a+1]),
            .zmask_out (zm_l[a+1]),
            .near_out  (near_l[a+1]),
            .far_out   (far_l[a+1])
        );
    end

    // Hit: zero axes inside and, if any axis folded, a non-empty interval ending >= 0
    assign hit_next = flg[NA].contained &&
                      (!flg[NA].have ||
                       ((far_l[NA] >= near_l[NA]) && !far_l[NA][2*CW]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= flg[NA].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rbst_pkg::OUT_W-1){1'b0}}, hit_reg};

    // Held result keeps its value while the sink stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(hit_reg))
        else $error("result changed while stalled");

    // Ray with only zero axes, all inside, must hit
    a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
        en && flg[NA].valid && !flg[NA].have && flg[NA].contained |=> hit_reg)
        else $error("contained zero-direction ray reported a miss");

    // A failed zero-axis test always misses
    a_outside_miss: assert property (@(posedge clk) disable iff (!rst_n)
        en && flg[NA].valid && !flg[NA].contained |=> !hit_reg)
        else $error("ray outside a zero-direction slab reported a hit");

    // An empty interval always misses
    a_empty_miss: assert property (@(posedge clk) disable iff (!rst_n)
        en && flg[NA].valid && flg[NA].have && (far_l[NA] < near_l[NA]) |=> !hit_reg)
        else $error("empty interval reported a hit");

endmodule
